/* rtl/rmst_pkg.sv */
// ---------------------------------------------------------------------------
// Range maximum segment tree package
// Sizes, codes, state encoding and helpers shared by the tree block.
// ---------------------------------------------------------------------------
package rmst_pkg;

	localparam int TREE_LEAVES = 1024;
	localparam int LEAF_W      = $clog2(TREE_LEAVES);
	localparam int NODE_W      = LEAF_W + 1;
	localparam int NODE_COUNT  = 2 * TREE_LEAVES;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 10;
	localparam int HIGH_W  = 11;
	localparam int TDATA_W = 64;

	localparam logic [POS_W-1:0]          LAST_POS = POS_W'(TREE_LEAVES - 3);
	localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef logic [NODE_W-1:0] node_idx_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// transaction kinds carried on tuser
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_LEAF,
		ST_WR_UP,
		ST_Q_LEFT,
		ST_Q_RIGHT,
		ST_Q_DONE
	} state_t;

	function automatic value_t max_val(value_t a, value_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* rtl/rmst_ram.sv */
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module rmst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/range_max_segment_tree.sv */
// ---------------------------------------------------------------------------
// Range maximum segment tree
// Bottom-up segment tree of signed 32-bit values with point write and
// inclusive range maximum query, state held in one node RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser selects the transaction kind, 0 = write,
//   1 = range maximum query. A write stores value at position and rebuilds
//   every ancestor; it returns nothing. A query returns one transaction on
//   m_axis with the maximum over range_low..range_high (inclusive).
//   An empty range (range_low above range_high, or a negative range_high)
//   and never-written positions give the most negative value. A write to a
//   position past the last usable one is dropped; range_high saturates.
// Timing:
//   A write occupies the block while it stores the leaf, then one ancestor
//   per cycle, each write paired with the read of the next sibling on the
//   RAM's second port. A query alternates reads of the left and the right
//   bound's siblings for each tree level it climbs, at most nine here,
//   then finishes; the single read port sets this.
// Reset:
//   After arst_n releases, a clearing pass writes the most negative value
//   to all 2048 nodes, one per cycle; s_axis_tready stays low meanwhile.
// Back-pressure:
//   Results sit in an output register, so the next transaction is taken
//   while a result waits; a finished query holds until that register frees.
// ---------------------------------------------------------------------------
module range_max_segment_tree (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] position, [41:10] value, [51:42] range_low, [62:52] range_high,
	// [63] zero
	input  logic [63:0] s_axis_tdata,
	// [0] action
	input  logic        s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] max_value
	output logic [31:0] m_axis_tdata
);

	// Input fields
	logic [rmst_pkg::POS_W-1:0]  in_pos;
	rmst_pkg::value_t            in_value;
	logic [rmst_pkg::POS_W-1:0]  in_lo;
	logic [rmst_pkg::HIGH_W-1:0] in_hi;
	logic                        in_action;

	assign in_pos    = s_axis_tdata[9:0];
	assign in_value  = s_axis_tdata[41:10];
	assign in_lo     = s_axis_tdata[51:42];
	assign in_hi     = s_axis_tdata[62:52];
	assign in_action = s_axis_tuser;

	rmst_pkg::state_t state_q, state_d;

	// Walk registers
	rmst_pkg::node_idx_t node_q;   // current node of a write walk
	rmst_pkg::value_t    cur_q;    // value of that node
	rmst_pkg::node_idx_t l_q;      // exclusive left bound of a query
	rmst_pkg::node_idx_t r_q;      // exclusive right bound of a query
	rmst_pkg::value_t    best_q;   // running maximum
	logic                pend_q;   // RAM data from last cycle is to be folded
	rmst_pkg::node_idx_t clr_q;    // clearing pass address

	logic             out_valid_q;
	rmst_pkg::value_t out_data_q;

	// RAM port
	logic                ram_we;
	rmst_pkg::node_idx_t ram_waddr;
	rmst_pkg::value_t    ram_wdata;
	rmst_pkg::node_idx_t ram_raddr;
	rmst_pkg::value_t    ram_rdata;

	rmst_ram #(
		.WIDTH(rmst_pkg::VALUE_W),
		.DEPTH(rmst_pkg::NODE_COUNT)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Decode of the incoming transaction
	logic                       accept;
	logic                       wr_skip;
	logic [rmst_pkg::POS_W-1:0] hi_sat;
	logic                       q_empty;
	rmst_pkg::node_idx_t        leaf_idx;
	rmst_pkg::node_idx_t        l_init;
	rmst_pkg::node_idx_t        r_init;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign wr_skip  = in_pos > rmst_pkg::LAST_POS;
	assign hi_sat   = (in_hi[rmst_pkg::POS_W-1:0] > rmst_pkg::LAST_POS) ?
		rmst_pkg::LAST_POS : in_hi[rmst_pkg::POS_W-1:0];
	// top bit of range_high set means it is negative: empty range
	assign q_empty  = in_hi[rmst_pkg::HIGH_W-1] || (in_lo > hi_sat);
	assign leaf_idx = rmst_pkg::NODE_W'(rmst_pkg::TREE_LEAVES) +
		rmst_pkg::NODE_W'(in_pos) + rmst_pkg::NODE_W'(1);
	assign l_init   = rmst_pkg::NODE_W'(rmst_pkg::TREE_LEAVES) + rmst_pkg::NODE_W'(in_lo);
	assign r_init   = rmst_pkg::NODE_W'(rmst_pkg::TREE_LEAVES) +
		rmst_pkg::NODE_W'(hi_sat) + rmst_pkg::NODE_W'(2);

	// Walk helpers
	rmst_pkg::node_idx_t parent;
	rmst_pkg::value_t    wr_max;
	rmst_pkg::value_t    best_next;
	logic                q_term;
	logic                out_free;
	logic                clr_last;

	assign parent    = node_q >> 1;
	assign wr_max    = rmst_pkg::max_val(cur_q, ram_rdata);
	assign best_next = pend_q ? rmst_pkg::max_val(best_q, ram_rdata) : best_q;
	// bounds are siblings: nothing left between them
	assign q_term    = (l_q ^ r_q) == rmst_pkg::NODE_W'(1);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign clr_last  = clr_q == rmst_pkg::NODE_W'(rmst_pkg::NODE_COUNT - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmst_pkg::ST_CLEAR: begin
				if (clr_last) state_d = rmst_pkg::ST_IDLE;
			end
			rmst_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_action == rmst_pkg::ACT_WRITE) begin
						state_d = wr_skip ? rmst_pkg::ST_IDLE : rmst_pkg::ST_WR_LEAF;
					end else begin
						state_d = q_empty ? rmst_pkg::ST_Q_DONE : rmst_pkg::ST_Q_LEFT;
					end
				end
			end
			rmst_pkg::ST_WR_LEAF: state_d = rmst_pkg::ST_WR_UP;
			rmst_pkg::ST_WR_UP: begin
				if (parent == rmst_pkg::NODE_W'(1)) state_d = rmst_pkg::ST_IDLE;
			end
			rmst_pkg::ST_Q_LEFT: begin
				state_d = q_term ? rmst_pkg::ST_Q_DONE : rmst_pkg::ST_Q_RIGHT;
			end
			rmst_pkg::ST_Q_RIGHT: state_d = rmst_pkg::ST_Q_LEFT;
			rmst_pkg::ST_Q_DONE: begin
				if (out_free) state_d = rmst_pkg::ST_IDLE;
			end
			default: state_d = rmst_pkg::ST_IDLE;
		endcase
	end

	// RAM control and handshake
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = clr_q;
		ram_wdata     = rmst_pkg::MOST_NEG;
		ram_raddr     = '0;
		unique case (state_q)
			rmst_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			rmst_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			rmst_pkg::ST_WR_LEAF: begin
				// store the leaf, fetch its sibling
				ram_we    = 1'b1;
				ram_waddr = node_q;
				ram_wdata = cur_q;
				ram_raddr = node_q ^ rmst_pkg::NODE_W'(1);
			end
			rmst_pkg::ST_WR_UP: begin
				// store the parent, fetch the parent's sibling
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = wr_max;
				ram_raddr = parent ^ rmst_pkg::NODE_W'(1);
			end
			rmst_pkg::ST_Q_LEFT:  ram_raddr = l_q ^ rmst_pkg::NODE_W'(1);
			rmst_pkg::ST_Q_RIGHT: ram_raddr = r_q ^ rmst_pkg::NODE_W'(1);
			rmst_pkg::ST_Q_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmst_pkg::ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rmst_pkg::ST_CLEAR) begin
				clr_q <= clr_q + rmst_pkg::NODE_W'(1);
			end
			// fold the read issued this cycle on the next one
			case (state_q)
				rmst_pkg::ST_Q_LEFT:  pend_q <= !q_term && !l_q[0];
				rmst_pkg::ST_Q_RIGHT: pend_q <= r_q[0];
				default:              pend_q <= 1'b0;
			endcase
			if (state_q == rmst_pkg::ST_Q_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			node_q <= leaf_idx;
			cur_q  <= in_value;
			l_q    <= l_init;
			r_q    <= r_init;
			best_q <= rmst_pkg::MOST_NEG;
		end else begin
			best_q <= best_next;
			if (state_q == rmst_pkg::ST_WR_UP) begin
				node_q <= parent;
				cur_q  <= wr_max;
			end
			if (state_q == rmst_pkg::ST_Q_RIGHT) begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
		end
		if (state_q == rmst_pkg::ST_Q_DONE && out_free) begin
			out_data_q <= best_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
